// File: design/mnps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mnps_pkg
// Types and constants for the mono note priority stack: payload structs,
// action and register codes, and the fixed-point constants of the level math.
// ----------------------------------------------------------------------------
package mnps_pkg;

  localparam int unsigned PAD_COUNT_DEF = 8;

  localparam int unsigned NOTE_W  = 4;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned HELD_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [2:0] {
    ACT_NONE            = 3'd0,
    ACT_STRIKE          = 3'd1,
    ACT_CLEAN_STRIKE    = 3'd2,
    ACT_BOW_GLIDE       = 3'd3,
    ACT_GLIDE_IF_BOWING = 3'd4,
    ACT_SILENCE         = 3'd5
  } action_e;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  localparam logic [1:0] EXC_PLUCK     = 2'd0;
  localparam logic [1:0] EXC_PLUCK_BOW = 2'd1;
  localparam logic [1:0] EXC_BOW       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCITER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_SCALE   = 2'd2;

  localparam logic [LEVEL_W-1:0] SOFT_SCALE_RST = 9'd256;

  // shared multiplier: a * b + c
  localparam int unsigned MUL_A_W = 20;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_C_W = 18;
  localparam int unsigned MUL_W   = 37;

  localparam logic [MUL_B_W-1:0] COEF_STEP  = 16'd1088;
  localparam logic [MUL_C_W-1:0] COEF_BASE  = 18'd49152;
  localparam logic [MUL_C_W-1:0] ROUND_PROD = 18'd163840;
  localparam logic [MUL_B_W-1:0] RECIP5     = 16'd52429;
  localparam logic [MUL_B_W-1:0] RET_MUL    = 16'd13;
  localparam logic [MUL_C_W-1:0] RET_RND    = 18'd10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 9'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR  = 9'd52;
  localparam logic [LEVEL_W-1:0] LEVEL_RETURN = 9'd154;

  typedef struct packed {
    logic               operation;
    logic [7:0]         pad;
    logic [LEVEL_W-1:0] velocity;
  } in_item_t;

  typedef struct packed {
    action_e            action;
    logic [NOTE_W-1:0]  target_note;
    logic [LEVEL_W-1:0] drive_level;
    logic [HELD_W-1:0]  held_count;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/mono_note_priority_stack_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mono_note_priority_stack_core
// Pad note events in, one voice action per event out, with a last-note
// priority stack for mono mode and per-pad pressure levels.
// ----------------------------------------------------------------------------
// One event is worked on at a time and gives exactly one result. A pad out of
// range goes from idle straight to the output state, and so does a poly note
// off; a poly note on first makes three passes through the shared multiplier
// for the velocity scaling. A mono event adds the stack walk: a search step
// per entry searched, then, when the pad is found, a shift step per entry
// above it plus one step to drop the count, then the push or the top read,
// and two multiplier passes and the pick of the quotient for a note off in
// pluck-with-bow mode. The single multiplier and the single read port of the
// stack are why the work is spread over these steps. A new event is taken as
// soon as the previous result is in the output register, even while it waits
// there.
module mono_note_priority_stack_core #(
  parameter int unsigned PAD_COUNT = mnps_pkg::PAD_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mnps_pkg::in_item_t              in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mnps_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mnps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mnps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mnps_pkg::*;

  localparam int unsigned IdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int unsigned CntW = $clog2(PAD_COUNT + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_COEF   = 4'd1;
  localparam logic [3:0] ST_PROD   = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_EFF    = 4'd4;
  localparam logic [3:0] ST_SEARCH = 4'd5;
  localparam logic [3:0] ST_SHIFT  = 4'd6;
  localparam logic [3:0] ST_PUSH   = 4'd7;
  localparam logic [3:0] ST_TOP    = 4'd8;
  localparam logic [3:0] ST_P13    = 4'd9;
  localparam logic [3:0] ST_PDIV   = 4'd10;
  localparam logic [3:0] ST_PFIN   = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               mono_q, mono_d;
  logic [1:0]         exc_q, exc_d;
  logic [LEVEL_W-1:0] soft_q, soft_d;
  logic               out_valid_q, out_valid_d;

  in_item_t           item_q, item_d;
  action_e            act_q, act_d;
  logic [NOTE_W-1:0]  tgt_q, tgt_d;
  logic [LEVEL_W-1:0] drv_q, drv_d;
  logic [MUL_W-1:0]   mul_q, mul_d;
  out_item_t          out_q, out_d;

  logic [NOTE_W-1:0]  stack_q [PAD_COUNT];
  logic [LEVEL_W-1:0] level_q [PAD_COUNT];

  logic               stack_we;
  logic [IdxW-1:0]    stack_waddr;
  logic [NOTE_W-1:0]  stack_wdata;
  logic               lvl_we;
  logic [IdxW-1:0]    lvl_waddr;
  logic [LEVEL_W-1:0] lvl_wdata;

  logic [CntW-1:0]    rd_addr;
  logic [NOTE_W-1:0]  stack_rd;
  logic [LEVEL_W-1:0] top_level;
  logic [LEVEL_W-1:0] p_ret;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_C_W-1:0] mul_c;
  logic [12:0]        eff_raw;
  logic [LEVEL_W-1:0] eff;
  logic               bow_only, pluck_bow, in_range, last_idx;
  logic [IdxW-1:0]    pad_idx;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign bow_only  = (exc_q == EXC_BOW);
  assign pluck_bow = (exc_q == EXC_PLUCK_BOW);
  assign in_range  = (in_item_i.pad < 8'(PAD_COUNT));
  assign pad_idx   = item_q.pad[IdxW-1:0];
  assign last_idx  = ((idx_q + 1'b1) == count_q);

  always_comb begin
    case (state_q)
      ST_SEARCH: rd_addr = idx_q;
      ST_SHIFT:  rd_addr = idx_q + 1'b1;
      default:   rd_addr = count_q - 1'b1;
    endcase
  end

  assign stack_rd  = stack_q[rd_addr[IdxW-1:0]];
  assign top_level = level_q[stack_rd[IdxW-1:0]];
  assign p_ret     = (top_level < LEVEL_FLOOR) ? LEVEL_RETURN : top_level;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (state_q)
      ST_COEF: begin
        mul_a = MUL_A_W'(soft_q);
        mul_b = COEF_STEP;
        mul_c = COEF_BASE;
      end
      ST_PROD: begin
        mul_a = mul_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(item_q.velocity);
        mul_c = ROUND_PROD;
      end
      ST_DIV: begin
        mul_a = MUL_A_W'(mul_q[28:16]);
        mul_b = RECIP5;
      end
      ST_P13: begin
        mul_a = MUL_A_W'(drv_q);
        mul_b = RET_MUL;
        mul_c = RET_RND;
      end
      ST_PDIV: begin
        mul_a = MUL_A_W'(mul_q[11:2]);
        mul_b = RECIP5;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_d   = MUL_W'(mul_a) * MUL_W'(mul_b) + MUL_W'(mul_c);
  assign eff_raw = mul_q[30:18];
  assign eff     = (eff_raw > 13'(LEVEL_MAX)) ? LEVEL_MAX : eff_raw[LEVEL_W-1:0];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    mono_d      = mono_q;
    exc_d       = exc_q;
    soft_d      = soft_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    act_d       = act_q;
    tgt_d       = tgt_q;
    drv_d       = drv_q;
    out_d       = out_q;
    stack_we    = 1'b0;
    stack_waddr = idx_q[IdxW-1:0];
    stack_wdata = stack_rd;
    lvl_we      = 1'b0;
    lvl_waddr   = pad_idx;
    lvl_wdata   = eff;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MONO_MODE: begin
          if (cfg_data_i[0] != mono_q) begin
            mono_d  = cfg_data_i[0];
            count_d = '0;
          end
        end
        CFG_EXCITER_MODE: exc_d  = cfg_data_i[1:0];
        CFG_SOFT_SCALE:   soft_d = cfg_data_i;
        default:          exc_d  = exc_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          idx_d  = '0;
          tgt_d  = '0;
          drv_d  = '0;
          act_d  = ACT_NONE;
          if (!in_range) begin
            state_d = ST_OUT;
          end else if (in_item_i.operation == OP_NOTE_ON) begin
            state_d = ST_COEF;
          end else begin
            lvl_we    = 1'b1;
            lvl_waddr = in_item_i.pad[IdxW-1:0];
            lvl_wdata = '0;
            if (mono_q) begin
              state_d = (count_q == '0) ? ST_TOP : ST_SEARCH;
            end else begin
              act_d   = ACT_SILENCE;
              tgt_d   = in_item_i.pad[NOTE_W-1:0];
              state_d = ST_OUT;
            end
          end
        end
      end
      ST_COEF: state_d = ST_PROD;
      ST_PROD: state_d = ST_DIV;
      ST_DIV:  state_d = ST_EFF;
      ST_EFF: begin
        lvl_we = 1'b1;
        tgt_d  = item_q.pad[NOTE_W-1:0];
        drv_d  = eff;
        if (mono_q) begin
          act_d   = bow_only ? ACT_BOW_GLIDE : (pluck_bow ? ACT_STRIKE : ACT_CLEAN_STRIKE);
          state_d = (count_q == '0) ? ST_PUSH : ST_SEARCH;
        end else begin
          act_d   = bow_only ? ACT_BOW_GLIDE : ACT_CLEAN_STRIKE;
          state_d = ST_OUT;
        end
      end
      ST_SEARCH: begin
        if (stack_q[idx_q[IdxW-1:0]] == item_q.pad[NOTE_W-1:0]) begin
          state_d = ST_SHIFT;
        end else if (last_idx) begin
          state_d = (item_q.operation == OP_NOTE_ON) ? ST_PUSH : ST_TOP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (!last_idx) begin
          stack_we = 1'b1;
          idx_d    = idx_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = (item_q.operation == OP_NOTE_ON) ? ST_PUSH : ST_TOP;
        end
      end
      ST_PUSH: begin
        if (count_q < CntW'(PAD_COUNT)) begin
          stack_we    = 1'b1;
          stack_waddr = count_q[IdxW-1:0];
          stack_wdata = item_q.pad[NOTE_W-1:0];
          count_d     = count_q + 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_TOP: begin
        state_d = ST_OUT;
        if (count_q == '0) begin
          act_d = ACT_SILENCE;
        end else begin
          tgt_d = stack_rd;
          if (bow_only) begin
            act_d = ACT_BOW_GLIDE;
            drv_d = p_ret;
          end else if (pluck_bow) begin
            act_d   = ACT_GLIDE_IF_BOWING;
            drv_d   = p_ret;
            state_d = ST_P13;
          end else begin
            act_d = ACT_NONE;
          end
        end
      end
      ST_P13:  state_d = ST_PDIV;
      ST_PDIV: state_d = ST_PFIN;
      ST_PFIN: begin
        drv_d   = mul_q[26:18];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.action      = act_q;
          out_d.target_note = tgt_q;
          out_d.drive_level = drv_q;
          out_d.held_count  = HELD_W'(count_q);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      mono_q      <= 1'b0;
      exc_q       <= EXC_PLUCK;
      soft_q      <= SOFT_SCALE_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      mono_q      <= mono_d;
      exc_q       <= exc_d;
      soft_q      <= soft_d;
      out_valid_q <= out_valid_d;
      if (lvl_we) begin
        level_q[lvl_waddr] <= lvl_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    act_q  <= act_d;
    tgt_q  <= tgt_d;
    drv_q  <= drv_d;
    mul_q  <= mul_d;
    out_q  <= out_d;
    if (stack_we) begin
      stack_q[stack_waddr] <= stack_wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(PAD_COUNT))
    else $error("stack count above pad count");

  a_poly_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mono_q |-> (count_q == '0))
    else $error("stack not empty in poly mode");

  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH || state_q == ST_SHIFT) |-> (idx_q < count_q))
    else $error("stack walk past the top");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.drive_level <= LEVEL_MAX))
    else $error("drive level above full scale");
`endif

endmodule
`default_nettype wire

// File: tb/sv/note_stack_checker.sv
// ----------------------------------------------------------------------------
// note_stack_checker
// Watches the event, result and register channels of the mono note priority
// stack. Keeps its own copy of the pad levels, the held-pad stack and the
// register settings, works out the voice action for every accepted event and
// compares each accepted result, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module note_stack_checker import mnps_pkg::*; #(
  parameter int unsigned PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SCALE_DIV  = 327680;
  localparam longint unsigned RETURN_DIV = 20;

  logic               mono_q;
  logic [1:0]         exciter_q;
  logic [LEVEL_W-1:0] softness_q;
  logic [NOTE_W-1:0]  held_pads_q [$];
  logic [LEVEL_W-1:0] pad_level_q [PAD_COUNT];
  out_item_t          expected_actions_q [$];
  out_item_t          want_item;

  function automatic void drop_held(logic [NOTE_W-1:0] pad);
    for (int i = 0; i < held_pads_q.size(); i++) begin
      if (held_pads_q[i] == pad) begin
        held_pads_q.delete(i);
        return;
      end
    end
  endfunction

  function automatic out_item_t predict_voice_action(in_item_t ev);
    out_item_t          r;
    logic [1:0]         mode;
    logic [NOTE_W-1:0]  pad;
    logic [NOTE_W-1:0]  top_pad;
    longint unsigned    v;
    longint unsigned    s;
    longint unsigned    q;
    logic [LEVEL_W-1:0] eff;
    logic [LEVEL_W-1:0] lvl;
    r.action      = ACT_NONE;
    r.target_note = '0;
    r.drive_level = '0;
    mode = (exciter_q > EXC_BOW) ? EXC_PLUCK : exciter_q;
    pad  = ev.pad[NOTE_W-1:0];
    if (ev.pad < PAD_COUNT) begin
      if (ev.operation == OP_NOTE_ON) begin
        v   = ev.velocity;
        s   = softness_q;
        q   = (v * (COEF_BASE + COEF_STEP * s) + ROUND_PROD) / SCALE_DIV;
        eff = (q > LEVEL_MAX) ? LEVEL_MAX : q[LEVEL_W-1:0];
        pad_level_q[pad] = eff;
        r.target_note    = pad;
        r.drive_level    = eff;
        if (mono_q) begin
          drop_held(pad);
          if (held_pads_q.size() < PAD_COUNT) held_pads_q.push_back(pad);
          r.action = (mode == EXC_BOW) ? ACT_BOW_GLIDE :
                     (mode == EXC_PLUCK_BOW) ? ACT_STRIKE : ACT_CLEAN_STRIKE;
        end else begin
          r.action = (mode == EXC_BOW) ? ACT_BOW_GLIDE : ACT_CLEAN_STRIKE;
        end
      end else begin
        pad_level_q[pad] = '0;
        if (mono_q) begin
          drop_held(pad);
          if (held_pads_q.size() > 0) begin
            top_pad = held_pads_q[$];
            lvl     = pad_level_q[top_pad];
            if (lvl < LEVEL_FLOOR) lvl = LEVEL_RETURN;
            r.target_note = top_pad;
            if (mode == EXC_BOW) begin
              r.action      = ACT_BOW_GLIDE;
              r.drive_level = lvl;
            end else if (mode == EXC_PLUCK_BOW) begin
              q             = (longint'(lvl) * RET_MUL + RET_RND) / RETURN_DIV;
              r.action      = ACT_GLIDE_IF_BOWING;
              r.drive_level = q[LEVEL_W-1:0];
            end
          end else begin
            r.action = ACT_SILENCE;
          end
        end else begin
          r.action      = ACT_SILENCE;
          r.target_note = pad;
        end
      end
    end
    r.held_count = HELD_W'(held_pads_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q     = 1'b0;
      exciter_q  = EXC_PLUCK;
      softness_q = SOFT_SCALE_RST;
      held_pads_q.delete();
      expected_actions_q.delete();
      foreach (pad_level_q[i]) pad_level_q[i] = '0;
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MONO_MODE: begin
            if (cfg_data_i[0] != mono_q) begin
              mono_q = cfg_data_i[0];
              held_pads_q.delete();
            end
          end
          CFG_EXCITER_MODE: exciter_q = cfg_data_i[1:0];
          CFG_SOFT_SCALE: softness_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_actions_q.size() == 0) begin
          report_mismatch("result transfer with none pending", out_item_i.action, ACT_NONE);
        end else begin
          want_item = expected_actions_q.pop_front();
          if (out_item_i.action !== want_item.action)
            report_mismatch("action", out_item_i.action, want_item.action);
          if (out_item_i.target_note !== want_item.target_note)
            report_mismatch("target_note", out_item_i.target_note, want_item.target_note);
          if (out_item_i.drive_level !== want_item.drive_level)
            report_mismatch("drive_level", out_item_i.drive_level, want_item.drive_level);
          if (out_item_i.held_count !== want_item.held_count)
            report_mismatch("held_count", out_item_i.held_count, want_item.held_count);
        end
      end
      if (in_valid_i && in_ready_i) expected_actions_q.push_back(predict_voice_action(in_item_i));
      pending_o <= expected_actions_q.size();
    end
  end

endmodule

// File: tb/sv/tb_mono_note_priority_stack_core.sv
// ----------------------------------------------------------------------------
// tb_mono_note_priority_stack_core
// Drives pad note events and register writes into the note priority stack
// core: a directed pass over the edge cases, then random event streams under
// several register settings and idle patterns, with one long result stall.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_mono_note_priority_stack_core import mnps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned          PADS          = PAD_COUNT_DEF;
  localparam int                   RESET_CYCLES  = 12;
  localparam int                   HOLD_CYCLES   = 200;
  localparam int                   QUIET_LIMIT   = 4000;
  localparam int                   END_SETTLE    = 40;
  localparam int                   RANDOM_BLOCKS = 9;
  localparam int                   BLOCK_ITEMS   = 195;
  localparam logic [1:0]           EXC_RESERVED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    hold_requests;

  mono_note_priority_stack_core #(.PAD_COUNT(PADS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  note_stack_checker #(.PAD_COUNT(PADS)) action_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_event(input logic op, input logic [7:0] pad,
                            input logic [LEVEL_W-1:0] vel);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{operation: op, pad: pad, velocity: vel};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // unused upper data bits are randomized
  task automatic configure(input logic mono, input logic [1:0] exc,
                           input logic [LEVEL_W-1:0] soft_lvl);
    wait_idle();
    write_reg(CFG_MONO_MODE, {8'($urandom_range(255)), mono}, 1'b0);
    write_reg(CFG_EXCITER_MODE, {7'($urandom_range(127)), exc}, 1'b0);
    write_reg(CFG_SOFT_SCALE, soft_lvl, 1'b1);
  endtask

  initial begin : receiver
    int served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic               op;
    logic [7:0]         pad;
    logic [LEVEL_W-1:0] vel;
    logic [LEVEL_W-1:0] soft_lvl;
    int                 pick;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_item       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rx_idle_pct   <= 68;
    hold_requests <= 0;
    tx_idle_pct   = 34;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // poly at reset settings, pads out of range, saturated velocity
    send_event(OP_NOTE_ON, 8'd0, LEVEL_MAX);
    send_event(OP_NOTE_ON, 8'd7, 9'd0);
    send_event(OP_NOTE_ON, 8'd8, 9'h1FF);
    send_event(OP_NOTE_OFF, 8'd255, 9'd0);
    send_event(OP_NOTE_OFF, 8'd0, 9'd0);
    send_event(OP_NOTE_ON, 8'd3, 9'h1FF);

    // mono bow, softest: move to top, off of top, off of absent pad, low return level
    configure(1'b1, EXC_BOW, 9'd0);
    send_event(OP_NOTE_ON, 8'd2, LEVEL_MAX);
    send_event(OP_NOTE_ON, 8'd5, 9'd100);
    send_event(OP_NOTE_ON, 8'd2, LEVEL_MAX);
    send_event(OP_NOTE_OFF, 8'd5, 9'd0);
    send_event(OP_NOTE_OFF, 8'd2, 9'd0);
    send_event(OP_NOTE_OFF, 8'd6, 9'd0);
    send_event(OP_NOTE_ON, 8'd1, 9'd40);
    send_event(OP_NOTE_ON, 8'd4, 9'd300);
    send_event(OP_NOTE_OFF, 8'd4, 9'd0);

    // mono pluck with bow, softness out of range
    configure(1'b1, EXC_PLUCK_BOW, 9'h1FF);
    send_event(OP_NOTE_ON, 8'd7, 9'h1FF);
    send_event(OP_NOTE_OFF, 8'd7, 9'd0);
    send_event(OP_NOTE_OFF, 8'd1, 9'd0);

    // reserved exciter code and reserved register index
    configure(1'b1, EXC_RESERVED, SOFT_SCALE_RST);
    wait_idle();
    write_reg(CFG_RESERVED, 9'($urandom_range(511)), 1'b1);
    send_event(OP_NOTE_ON, 8'd0, 9'd200);
    send_event(OP_NOTE_ON, 8'd1, 9'd128);
    send_event(OP_NOTE_OFF, 8'd1, 9'd0);

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b / 3)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct <= 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct <= 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      case ($urandom_range(3))
        0: soft_lvl = '0;
        1: soft_lvl = SOFT_SCALE_RST;
        2: soft_lvl = 9'h1FF;
        default: soft_lvl = 9'($urandom_range(511));
      endcase
      configure(1'($urandom_range(1)), 2'($urandom_range(3)), soft_lvl);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (b == 1 && n == BLOCK_ITEMS / 2) wait_idle();
        if (b == 6 && n == 40) hold_requests <= hold_requests + 1;
        pick = $urandom_range(99);
        if (pick < 8) begin
          op  = 1'($urandom_range(1));
          pad = 8'($urandom_range(255, PADS));
        end else begin
          op  = ($urandom_range(99) < 58) ? OP_NOTE_ON : OP_NOTE_OFF;
          pad = 8'($urandom_range(PADS - 1));
        end
        case ($urandom_range(9))
          0: vel = '0;
          1: vel = LEVEL_MAX;
          2: vel = 9'($urandom_range(511));
          default: vel = 9'($urandom_range(256));
        endcase
        send_event(op, pad, vel);
      end
    end

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
